/* rtl/body_euler_integrator_defines.svh */
// Assertion macros shared by the integrator checker.
// No dependencies.
`ifndef BODY_EULER_INTEGRATOR_DEFINES_SVH
`define BODY_EULER_INTEGRATOR_DEFINES_SVH
// clocked implication with synchronous reset disable
`define BEI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BEI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/bei_pkg.sv */
// Package for the body integrator: operation codes, sequencer states, config indexes,
// saturation limits and a saturating helper. No dependencies.
package bei_pkg;
  typedef enum logic [1:0] {
    OP_ADD_FORCE = 2'd0,
    OP_SET_FORCE = 2'd1,
    OP_DISPLACE  = 2'd2,
    OP_STEP      = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_DIVFIN, ST_MULV, ST_ADDV, ST_MULP, ST_ADDP,
    ST_FIX, ST_GRAV, ST_OUT
  } state_t;

  localparam logic [2:0] CFG_MASS = 3'd0;
  localparam logic [2:0] CFG_HALF = 3'd1;
  localparam logic [2:0] CFG_GRAV = 3'd2;
  localparam logic [2:0] CFG_XLIM = 3'd3;
  localparam logic [2:0] CFG_ZLIM = 3'd4;
  localparam logic [2:0] CFG_TOP  = 3'd5;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh07fffffff) return SMAX;
    if (v < -34'sh080000000) return SMIN;
    return v[31:0];
  endfunction
endpackage

/* rtl/bei_if.sv */
// Valid/ready channel interfaces for items, results and config writes.
// Depends on nothing.
interface bei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [31:0] vec_x, vec_y, vec_z;
  logic [15:0] time_delta;
  modport source (output valid, operation, vec_x, vec_y, vec_z, time_delta, input ready);
  modport sink (input valid, operation, vec_x, vec_y, vec_z, time_delta, output ready);
endinterface

interface bei_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
  logic airborne;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y,
                  acc_z, airborne, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y,
                acc_z, airborne, output ready);
endinterface

interface bei_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/body_euler_integrator.sv */
// Body integrator top level: sequencer, one shared divider, one shared multiplier.
// Depends on bei_pkg and the channel interfaces in bei_if.sv.
//
// One item at a time. Force, set and displace items go from idle straight to the output state.
// A time step runs each axis through a restoring divider (one quotient bit a cycle),
// then two multiply and saturate-add passes, then the wrap, floor and gravity-reload
// states. The input is ready only while idle; the result register holds the item
// until it is taken. Config writes are always accepted.
module body_euler_integrator
  import bei_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  bei_in_if.sink   in_ch,
  bei_out_if.source out_ch,
  bei_cfg_if.sink  cfg
);
  localparam int QW = FRAC_BITS + 32;   // dividend bits
  localparam int CW = $clog2(QW + 1);

  state_t state, state_next;
  logic [24:0] body_mass;
  logic [19:0] half_height;
  logic [24:0] gravity;
  logic [30:0] x_limit, z_limit, top_limit;
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] frc [3];
  logic signed [31:0] acc [3];
  logic in_air;
  logic [1:0] axis;
  logic [15:0] dt;
  logic [CW-1:0] cnt;
  logic [QW-1:0] dvd;
  logic [QW:0] rem;
  logic signed [31:0] prod_r;

  // shared multiplier: floor of product >> FRAC_BITS, saturated
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  always_comb begin
    prod = mul_a * mul_b;
    prod_sh = prod >>> FRAC_BITS;
  end
  logic signed [31:0] prod_sat;
  assign prod_sat = (prod_sh > 64'sh7fffffff) ? SMAX :
                    (prod_sh < -64'sh80000000) ? SMIN : prod_sh[31:0];

  // shared adder
  logic signed [31:0] add_a, add_b;
  logic signed [31:0] add_sat;
  assign add_sat = sat34(34'(add_a) + 34'(add_b));

  always_comb begin
    mul_a = (state == ST_MULV) ? acc[axis] : (state == ST_MULP) ? vel[axis]
          : 32'(signed'({7'd0, gravity}));
    mul_b = (state == ST_GRAV) ? 32'(signed'({7'd0, body_mass})) : 32'(signed'({16'd0, dt}));
    add_a = (state == ST_ADDV) ? vel[axis] : pos[axis];
    add_b = (state == ST_IDLE) ? 32'sd0 : prod_r;
  end

  logic [QW:0] trial;
  assign trial = {rem[QW-1:0], dvd[QW-1]} - {{(QW-24){1'b0}}, body_mass};
  logic [QW-1:0] qmag;
  assign qmag = dvd;  // after the loop the dividend register holds the quotient

  logic f_neg;
  assign f_neg = frc[axis][31];
  logic signed [31:0] div_res;
  always_comb begin
    if (frc[axis] == 32'sd0) div_res = 32'sd0;
    else if (body_mass == 25'd0) div_res = f_neg ? SMIN : SMAX;
    else if (f_neg) div_res = (qmag > QW'(33'h80000000)) ? SMIN : -$signed(qmag[31:0]);
    else div_res = (qmag > QW'(33'h7fffffff)) ? SMAX : $signed(qmag[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_ch.valid) state_next = (op_t'(in_ch.operation) == OP_STEP) ? ST_DIV
                                                                                 : ST_OUT;
      ST_DIV:    if (cnt == CW'(QW - 1)) state_next = ST_DIVFIN;
      ST_DIVFIN: state_next = ST_MULV;
      ST_MULV:   state_next = ST_ADDV;
      ST_ADDV:   state_next = ST_MULP;
      ST_MULP:   state_next = ST_ADDP;
      ST_ADDP:   state_next = (axis == 2'd2) ? ST_FIX : ST_DIV;
      ST_FIX:    state_next = ST_GRAV;
      ST_GRAV:   state_next = ST_OUT;
      ST_OUT:    if (out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_ch.valid = (state == ST_OUT);

  logic signed [32:0] y_ov, x_w, z_w;
  logic signed [32:0] xl, zl;
  always_comb begin
    xl = 33'(x_limit);
    zl = 33'(z_limit);
    y_ov = 33'(pos[1]) - $signed(33'(top_limit));
    x_w = 33'(pos[0]);
    if (33'(pos[0]) > xl) x_w = 33'(pos[0]) - (xl <<< 1);
    else if (33'(pos[0]) < -xl) x_w = 33'(pos[0]) + (xl <<< 1);
    z_w = 33'(pos[2]);
    if (33'(pos[2]) > zl) z_w = 33'(pos[2]) - (zl <<< 1);
    else if (33'(pos[2]) < -zl) z_w = 33'(pos[2]) + (zl <<< 1);
  end
  logic signed [31:0] y_top;
  assign y_top = (33'(pos[1]) > $signed(33'(top_limit))) ? sat34(34'(y_ov)) : pos[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mass <= 25'd65536; half_height <= 20'd32768; gravity <= 25'd642908;
      x_limit <= 31'd327680; z_limit <= 31'd655360; top_limit <= 31'd327680;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0; vel[i] <= '0; acc[i] <= '0;
      end
      // gravity times mass at the reset register values
      frc[0] <= '0; frc[1] <= -32'sd642908; frc[2] <= '0;
      in_air <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_MASS: body_mass <= cfg.data[24:0];
          CFG_HALF: half_height <= cfg.data[19:0];
          CFG_GRAV: gravity <= cfg.data[24:0];
          CFG_XLIM: x_limit <= cfg.data[30:0];
          CFG_ZLIM: z_limit <= cfg.data[30:0];
          CFG_TOP:  top_limit <= cfg.data[30:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          dt <= in_ch.time_delta;
          axis <= 2'd0;
          cnt <= '0;
          rem <= '0;
          case (op_t'(in_ch.operation))
            OP_ADD_FORCE: begin
              frc[0] <= sat34(34'(frc[0]) + 34'(in_ch.vec_x));
              frc[1] <= sat34(34'(frc[1]) + 34'(in_ch.vec_y));
              frc[2] <= sat34(34'(frc[2]) + 34'(in_ch.vec_z));
            end
            OP_SET_FORCE: begin
              frc[0] <= in_ch.vec_x; frc[1] <= in_ch.vec_y; frc[2] <= in_ch.vec_z;
            end
            OP_DISPLACE: begin
              pos[0] <= sat34(34'(pos[0]) + 34'(in_ch.vec_x));
              pos[1] <= sat34(34'(pos[1]) + 34'(in_ch.vec_y));
              pos[2] <= sat34(34'(pos[2]) + 34'(in_ch.vec_z));
            end
            default: begin
              dvd <= {(frc[0][31] ? 32'(-frc[0]) : frc[0]), {FRAC_BITS{1'b0}}};
            end
          endcase
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (!trial[QW]) begin
            rem <= trial;
            dvd <= {dvd[QW-2:0], 1'b1};
          end else begin
            rem <= {rem[QW-1:0], dvd[QW-1]};
            dvd <= {dvd[QW-2:0], 1'b0};
          end
        end
        ST_DIVFIN: acc[axis] <= div_res;
        ST_MULV:   prod_r <= prod_sat;
        ST_ADDV:   vel[axis] <= add_sat;
        ST_MULP:   prod_r <= prod_sat;
        ST_ADDP: begin
          pos[axis] <= add_sat;
          axis <= axis + 1'b1;
          cnt <= '0;
          rem <= '0;
          dvd <= {(frc[axis + 2'd1][31] ? 32'(-frc[axis + 2'd1]) : frc[axis + 2'd1]),
                  {FRAC_BITS{1'b0}}};
        end
        ST_FIX: begin
          pos[0] <= sat34(34'(x_w));
          pos[2] <= sat34(34'(z_w));
          if (33'(y_top) <= $signed(33'(half_height)) && vel[1][31]) begin
            pos[1] <= 32'(half_height);
            vel[1] <= '0;
            in_air <= 1'b0;
          end else begin
            pos[1] <= y_top;
            in_air <= 1'b1;
          end
        end
        ST_GRAV: begin
          frc[0] <= '0;
          frc[1] <= -prod_sat;
          frc[2] <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.pos_x = pos[0];
  assign out_ch.pos_y = pos[1];
  assign out_ch.pos_z = pos[2];
  assign out_ch.vel_x = vel[0];
  assign out_ch.vel_y = vel[1];
  assign out_ch.vel_z = vel[2];
  assign out_ch.acc_x = acc[0];
  assign out_ch.acc_y = acc[1];
  assign out_ch.acc_z = acc[2];
  assign out_ch.airborne = in_air;
endmodule

/* rtl/bei_checker.sv */
// Port-level checker for the body integrator, bound to the top level.
// Depends on body_euler_integrator_defines.svh.
`include "body_euler_integrator_defines.svh"
module bei_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic airborne
);
  `BEI_ASSERT_IMPL(no_in_while_busy, clk, rst, out_valid, !in_ready, "input ready while result pending")
  `BEI_ASSERT_NEXT(result_after_take, clk, rst, out_valid && out_ready, !out_valid, "result repeated")
  `BEI_ASSERT_NEXT(hold_result, clk, rst, out_valid && !out_ready, out_valid && $stable(airborne), "result dropped")
endmodule

bind body_euler_integrator bei_checker u_bei_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .airborne(out_ch.airborne)
);

/* verif/body_euler_integrator_tb.sv */
// Self-checking testbench for body_euler_integrator: drives op items and config writes,
// predicts each result in a scoreboard class and compares field by field.
// Depends on bei_pkg, bei_if.sv and the RTL top level.
module tb;
  import bei_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz, ax, ay, az;
    logic air;
  } body_state_t;

  function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
    if (v > 66'sh0_7fffffff) return SMAX;
    if (v < -66'sh0_80000000) return SMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [65:0] p;
    p = $signed({{34{a[31]}}, a}) * $signed({{34{b[31]}}, b});
    return clip32(p >>> FB);
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] f,
                                              input logic [24:0] m);
    logic [65:0] mag, q;
    if (f == 0) return 0;
    if (m == 0) return f[31] ? SMIN : SMAX;
    mag = f[31] ? 66'(-$signed({{34{f[31]}}, f})) : 66'(f);
    q = (mag << FB) / m;
    if (q > (66'd1 << 40)) q = 66'd1 << 40;
    return f[31] ? clip32(-$signed(q)) : clip32($signed(q));
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return clip32($signed({{34{a[31]}}, a}) + $signed({{34{b[31]}}, b}));
  endfunction

  function automatic logic signed [31:0] wrap(input logic signed [31:0] p,
                                              input logic [30:0] lim);
    logic signed [65:0] v, l;
    v = p;
    l = $signed({35'd0, lim});
    if (v > l) v = v - 2 * l;
    else if (v < -l) v = v + 2 * l;
    return clip32(v);
  endfunction

  class body_scoreboard;
    logic [24:0] mass, grav;
    logic [19:0] half;
    logic [30:0] xlim, zlim, top;
    logic signed [31:0] pos[3], vel[3], frc[3], acc[3];
    logic air;
    body_state_t pending[$];
    int errors;

    function void reload_gravity();
      frc[0] = 0;
      frc[1] = -qmul($signed({7'd0, grav}), $signed({7'd0, mass}));
      frc[2] = 0;
    endfunction

    function void clear();
      mass = 65536; half = 32768; grav = 642908;
      xlim = 327680; zlim = 655360; top = 327680;
      foreach (pos[i]) begin
        pos[i] = 0; vel[i] = 0; acc[i] = 0;
      end
      reload_gravity();
      air = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_MASS: mass = d[24:0];
        CFG_HALF: half = d[19:0];
        CFG_GRAV: grav = d[24:0];
        CFG_XLIM: xlim = d[30:0];
        CFG_ZLIM: zlim = d[30:0];
        CFG_TOP: top = d[30:0];
        default: ;
      endcase
    endfunction

    function void note_item(op_t op, logic signed [31:0] v[3], logic [15:0] dt);
      logic signed [31:0] d;
      body_state_t s;
      d = $signed({16'd0, dt});
      case (op)
        OP_ADD_FORCE: foreach (frc[i]) frc[i] = qadd(frc[i], v[i]);
        OP_SET_FORCE: foreach (frc[i]) frc[i] = v[i];
        OP_DISPLACE: foreach (pos[i]) pos[i] = qadd(pos[i], v[i]);
        default: begin
          foreach (pos[i]) begin
            acc[i] = qdiv(frc[i], mass);
            vel[i] = qadd(vel[i], qmul(acc[i], d));
            pos[i] = qadd(pos[i], qmul(vel[i], d));
          end
          pos[0] = wrap(pos[0], xlim);
          pos[2] = wrap(pos[2], zlim);
          if ($signed({pos[1][31], pos[1]}) > $signed({2'b0, top}))
            pos[1] = qadd(pos[1], -$signed({1'b0, top}));
          if ($signed({pos[1][31], pos[1]}) <= $signed({13'd0, half}) && vel[1] < 0) begin
            pos[1] = {12'd0, half};
            vel[1] = 0;
            air = 0;
          end else begin
            air = 1;
          end
          reload_gravity();
        end
      endcase
      s = '{pos[0], pos[1], pos[2], vel[0], vel[1], vel[2], acc[0], acc[1], acc[2], air};
      pending.push_back(s);
    endfunction

    function void check_result(body_state_t got);
      body_state_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.px !== got.px) report("pos_x", e.px, got.px);
      if (e.py !== got.py) report("pos_y", e.py, got.py);
      if (e.pz !== got.pz) report("pos_z", e.pz, got.pz);
      if (e.vx !== got.vx) report("vel_x", e.vx, got.vx);
      if (e.vy !== got.vy) report("vel_y", e.vy, got.vy);
      if (e.vz !== got.vz) report("vel_z", e.vz, got.vz);
      if (e.ax !== got.ax) report("acc_x", e.ax, got.ax);
      if (e.ay !== got.ay) report("acc_y", e.ay, got.ay);
      if (e.az !== got.az) report("acc_z", e.az, got.az);
      if (e.air !== got.air) report("airborne", e.air, got.air);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] a);
      $display("%0t %s expected %h actual %h", $time, f, e, a);
      errors++;
    endfunction
  endclass

  logic clk, rst;
  bei_in_if in_ch();
  bei_out_if out_ch();
  bei_cfg_if cfg();

  body_euler_integrator #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  body_scoreboard sb;
  int send_idle, recv_idle, stall_cnt;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random backpressure, check at rising edge
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.vel_x,
                        out_ch.vel_y, out_ch.vel_z, out_ch.acc_x, out_ch.acc_y,
                        out_ch.acc_z, out_ch.airborne});
  end
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  // watchdog on acceptance of anything
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt > STALL_LIMIT) begin
        $display("[body_euler_integrator] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_vec();
    case ($urandom_range(5))
      0: return SMAX;
      1: return SMIN;
      2: return $urandom;
      default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  task automatic send_item(op_t op, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [15:0] dt);
    logic signed [31:0] v[3];
    // step past the falling edge that dropped the previous valid
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    v[0] = x; v[1] = y; v[2] = z;
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.vec_x <= x; in_ch.vec_y <= y; in_ch.vec_z <= z;
    in_ch.time_delta <= dt;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, v, dt);
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic random_item();
    op_t op;
    int r;
    r = $urandom_range(99);
    op = r < 40 ? OP_STEP : r < 65 ? OP_ADD_FORCE : r < 82 ? OP_SET_FORCE : OP_DISPLACE;
    send_item(op, rand_vec(), rand_vec(), rand_vec(),
              $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2000)));
  endtask

  task automatic random_config();
    write_reg(CFG_MASS, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 18));
    write_reg(CFG_HALF, $urandom);
    write_reg(CFG_GRAV, $urandom_range(1) ? $urandom : $urandom_range(1 << 20));
    write_reg(CFG_XLIM, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
    write_reg(CFG_ZLIM, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
    write_reg(CFG_TOP, $urandom_range(1) ? $urandom : $urandom_range(1 << 22));
    write_reg(3'd7, $urandom);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1;
    send_idle = 37; recv_idle = 62;
    in_ch.valid = 0; in_ch.operation = OP_ADD_FORCE;
    in_ch.vec_x = 0; in_ch.vec_y = 0; in_ch.vec_z = 0; in_ch.time_delta = 0;
    out_ch.ready = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: defaults, falling to floor, extremes, wraps
    send_item(OP_STEP, 0, 0, 0, 16'hffff);
    send_item(OP_STEP, 0, 0, 0, 0);
    send_item(OP_ADD_FORCE, SMAX, SMAX, SMIN, 0);
    send_item(OP_ADD_FORCE, SMAX, SMIN, SMIN, 0);
    send_item(OP_STEP, 0, 0, 0, 16'hffff);
    send_item(OP_SET_FORCE, 0, 32'sd5000000, 0, 0);
    send_item(OP_STEP, 0, 0, 0, 16'h8000);
    send_item(OP_DISPLACE, 32'sd400000, 32'sd400000, -32'sd700000, 0);
    send_item(OP_STEP, 0, 0, 0, 16'd1);
    send_item(OP_DISPLACE, SMAX, SMAX, SMAX, 0);
    send_item(OP_DISPLACE, SMIN, SMIN, SMIN, 0);
    send_item(OP_DISPLACE, SMIN, SMIN, SMIN, 0);
    send_item(OP_STEP, 0, 0, 0, 16'd100);
    send_item(OP_SET_FORCE, SMIN, SMAX, 32'hffffffff, 0);
    drain();
    write_reg(CFG_MASS, 0);
    write_reg(CFG_HALF, 32'hffffffff);
    write_reg(CFG_GRAV, 32'hffffffff);
    write_reg(CFG_XLIM, 0);
    write_reg(CFG_ZLIM, 32'hffffffff);
    write_reg(CFG_TOP, 0);
    write_reg(3'd6, 32'h1234);
    send_item(OP_STEP, 0, 0, 0, 16'h1000);
    send_item(OP_SET_FORCE, 0, 0, 0, 0);
    send_item(OP_STEP, 0, 0, 0, 16'h1000);
    send_item(OP_STEP, 0, 0, 0, 16'hffff);
    drain();
    write_reg(CFG_MASS, 32'd16777216);
    write_reg(CFG_GRAV, 0);
    write_reg(CFG_HALF, 0);
    write_reg(CFG_XLIM, 32'h40000000);
    write_reg(CFG_TOP, 32'h40000000);
    send_item(OP_STEP, 0, 0, 0, 16'h4000);
    send_item(OP_STEP, 0, 0, 0, 16'h4000);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 37 : phase == 1 ? 62 : 0;
      recv_idle = phase == 0 ? 62 : phase == 1 ? 37 : 0;
      for (int n = 0; n < 340; n++) begin
        if (n % 85 == 0) begin
          drain();
          random_config();
        end
        random_item();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[body_euler_integrator] OK");
    end else begin
      $display("[body_euler_integrator] ERROR");
    end
    $finish;
  end
endmodule

/* body_euler_integrator.f */
+incdir+rtl
rtl/bei_pkg.sv
rtl/bei_if.sv
rtl/body_euler_integrator.sv
rtl/bei_checker.sv
verif/body_euler_integrator_tb.sv
